// File: sv/lqc_pkg.sv
// Shared constants and types for the LLMNR query classifier.
package lqc_pkg;

	localparam int MAX_NAME_BYTES   = 56;
	localparam int MAX_PACKET_BYTES = 2048;
	localparam int NAME_WORDS       = 7;
	localparam int NAME_BITS        = NAME_WORDS * 64;
	localparam int HDR_BYTES        = 12;
	localparam int POS_W            = 12;
	localparam int CFG_IDX_W        = 3;
	localparam int HLEN_W           = 6;

	localparam logic [CFG_IDX_W-1:0] REG_HOSTNAME_LEN   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HOSTNAME_WORD0 = 3'd1;

	localparam logic [15:0] FLAG_MASK = 16'hF800;
	localparam logic [15:0] CLASS_IN  = 16'd1;
	localparam logic [15:0] TYPE_A    = 16'd1;
	localparam logic [15:0] TYPE_AAAA = 16'd28;
	localparam logic [15:0] TYPE_ANY  = 16'd255;

	localparam logic [1:0] FAMILY_ANY  = 2'd0;
	localparam logic [1:0] FAMILY_IPV4 = 2'd1;
	localparam logic [1:0] FAMILY_IPV6 = 2'd2;

	typedef enum logic [2:0] {
		VERDICT_RESPOND       = 3'd0,
		VERDICT_SHORT_HEADER  = 3'd1,
		VERDICT_BAD_HEADER    = 3'd2,
		VERDICT_BAD_NAME      = 3'd3,
		VERDICT_NAME_MISMATCH = 3'd4,
		VERDICT_SHORT_QUEST   = 3'd5,
		VERDICT_CLASS_NOT_IN  = 3'd6,
		VERDICT_TYPE_UNSUPP   = 3'd7
	} verdict_t;

	typedef struct packed {
		logic [HLEN_W-1:0]    len;
		logic [NAME_BITS-1:0] name;
	} host_cfg_t;

	typedef struct packed {
		verdict_t    verdict;
		logic [1:0]  family;
		logic [15:0] ident;
	} result_t;

endpackage

// File: sv/lqc_cfg_regs.sv
// Host name configuration registers.
module lqc_cfg_regs (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              wr_en,
	input  logic [lqc_pkg::CFG_IDX_W-1:0]     wr_index,
	input  logic [63:0]                       wr_data,
	output lqc_pkg::host_cfg_t                cfg
);

	logic [lqc_pkg::HLEN_W-1:0] len_q;
	logic [63:0]                word_q [lqc_pkg::NAME_WORDS];
	logic [lqc_pkg::CFG_IDX_W-1:0] word_idx;

	assign word_idx = wr_index - lqc_pkg::REG_HOSTNAME_WORD0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
			for (int i = 0; i < lqc_pkg::NAME_WORDS; i++) begin
				word_q[i] <= '0;
			end
		end else if (wr_en) begin
			if (wr_index == lqc_pkg::REG_HOSTNAME_LEN) begin
				len_q <= wr_data[lqc_pkg::HLEN_W-1:0];
			end else begin
				word_q[word_idx] <= wr_data;
			end
		end
	end

	always_comb begin
		cfg.len = len_q;
		for (int i = 0; i < lqc_pkg::NAME_WORDS; i++) begin
			cfg.name[i*64 +: 64] = word_q[i];
		end
	end

endmodule

// File: sv/lqc_parser.sv
// Per-packet parse state and verdict logic, one byte per beat.
module lqc_parser (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 accept,
	input  logic [7:0]           data_byte,
	input  logic                 last_byte,
	input  lqc_pkg::host_cfg_t   cfg,
	output lqc_pkg::result_t     res
);

	localparam logic [lqc_pkg::POS_W-1:0] HDR  = lqc_pkg::POS_W'(lqc_pkg::HDR_BYTES);
	localparam logic [lqc_pkg::POS_W-1:0] PMAX = lqc_pkg::POS_W'(lqc_pkg::MAX_PACKET_BYTES);
	localparam logic [lqc_pkg::POS_W-1:0] NMAX = lqc_pkg::POS_W'(lqc_pkg::MAX_NAME_BYTES);

	function automatic logic [7:0] fold(input logic [7:0] c);
		return (c >= 8'h41 && c <= 8'h5A) ? c + 8'h20 : c;
	endfunction

	logic [lqc_pkg::POS_W-1:0] pos_q, pos_n;
	logic [15:0] flags_q, flags_n, qdcount_q, qdcount_n, ident_q, ident_n;
	logic [15:0] qtype_q, qtype_n, qclass_q, qclass_n;
	logic [7:0]  label_q, label_n;
	logic        records_q, records_n, differs_q, differs_n, end_bad_q, end_bad_n;

	logic [7:0]  name_bytes [lqc_pkg::MAX_NAME_BYTES];
	logic [lqc_pkg::POS_W-1:0] name_end, k, len12, lab12;
	logic [7:0]  host_b;
	logic [lqc_pkg::HLEN_W-1:0] hlen;

	always_comb begin
		for (int i = 0; i < lqc_pkg::MAX_NAME_BYTES; i++) begin
			name_bytes[i] = cfg.name[i*8 +: 8];
		end
	end

	assign hlen     = cfg.len;
	assign name_end = HDR + {4'b0, label_q};
	assign k        = pos_q - HDR - 12'd1;
	assign host_b   = (k < NMAX) ? name_bytes[k[lqc_pkg::HLEN_W-1:0]] : 8'h00;

	// next packet state for the byte at the current position
	always_comb begin
		pos_n = pos_q; flags_n = flags_q; qdcount_n = qdcount_q; ident_n = ident_q;
		qtype_n = qtype_q; qclass_n = qclass_q; label_n = label_q;
		records_n = records_q; differs_n = differs_q; end_bad_n = end_bad_q;
		if (pos_q < PMAX) begin
			pos_n = pos_q + 12'd1;
			if (pos_q < HDR) begin
				unique case (pos_q[3:0])
					4'd0: ident_n[15:8]   = data_byte;
					4'd1: ident_n[7:0]    = data_byte;
					4'd2: flags_n[15:8]   = data_byte;
					4'd3: flags_n[7:0]    = data_byte;
					4'd4: qdcount_n[15:8] = data_byte;
					4'd5: qdcount_n[7:0]  = data_byte;
					4'd6, 4'd7, 4'd8, 4'd9: begin
						if (data_byte != 8'h00) records_n = 1'b1;
					end
					default: ;
				endcase
			end else if (pos_q == HDR) begin
				label_n = data_byte;
			end else if (pos_q <= name_end) begin
				if (k >= {6'b0, hlen} || k >= NMAX || fold(data_byte) != fold(host_b))
					differs_n = 1'b1;
			end else if (pos_q == name_end + 12'd1) begin
				if (data_byte != 8'h00) end_bad_n = 1'b1;
			end else if (pos_q == name_end + 12'd2) begin
				qtype_n[15:8] = data_byte;
			end else if (pos_q == name_end + 12'd3) begin
				qtype_n[7:0] = data_byte;
			end else if (pos_q == name_end + 12'd4) begin
				qclass_n[15:8] = data_byte;
			end else if (pos_q == name_end + 12'd5) begin
				qclass_n[7:0] = data_byte;
			end
		end
	end

	// verdict on the state after this byte; only used on the last beat
	assign len12 = pos_n;
	assign lab12 = {4'b0, label_n};

	always_comb begin
		res.family = lqc_pkg::FAMILY_ANY;
		res.ident  = ident_n;
		priority if (len12 < HDR) begin
			res.verdict = lqc_pkg::VERDICT_SHORT_HEADER;
		end else if ((flags_n & lqc_pkg::FLAG_MASK) != 16'h0 || qdcount_n != 16'd1
				|| records_n) begin
			res.verdict = lqc_pkg::VERDICT_BAD_HEADER;
		end else if (label_n == 8'h00 || len12 < HDR + lab12 + 12'd2 || end_bad_n) begin
			res.verdict = lqc_pkg::VERDICT_BAD_NAME;
		end else if (hlen == '0 || {6'b0, hlen} > NMAX || lab12 != {6'b0, hlen}
				|| differs_n) begin
			res.verdict = lqc_pkg::VERDICT_NAME_MISMATCH;
		end else if (len12 < HDR + lab12 + 12'd6) begin
			res.verdict = lqc_pkg::VERDICT_SHORT_QUEST;
		end else if (qclass_n != lqc_pkg::CLASS_IN) begin
			res.verdict = lqc_pkg::VERDICT_CLASS_NOT_IN;
		end else if (qtype_n == lqc_pkg::TYPE_A) begin
			res.verdict = lqc_pkg::VERDICT_RESPOND;
			res.family  = lqc_pkg::FAMILY_IPV4;
		end else if (qtype_n == lqc_pkg::TYPE_AAAA) begin
			res.verdict = lqc_pkg::VERDICT_RESPOND;
			res.family  = lqc_pkg::FAMILY_IPV6;
		end else if (qtype_n == lqc_pkg::TYPE_ANY) begin
			res.verdict = lqc_pkg::VERDICT_RESPOND;
		end else begin
			res.verdict = lqc_pkg::VERDICT_TYPE_UNSUPP;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0; flags_q <= '0; qdcount_q <= '0; ident_q <= '0;
			qtype_q <= '0; qclass_q <= '0; label_q <= '0;
			records_q <= 1'b0; differs_q <= 1'b0; end_bad_q <= 1'b0;
		end else if (accept) begin
			if (last_byte) begin
				pos_q <= '0; flags_q <= '0; qdcount_q <= '0; ident_q <= '0;
				qtype_q <= '0; qclass_q <= '0; label_q <= '0;
				records_q <= 1'b0; differs_q <= 1'b0; end_bad_q <= 1'b0;
			end else begin
				pos_q <= pos_n; flags_q <= flags_n; qdcount_q <= qdcount_n;
				ident_q <= ident_n; qtype_q <= qtype_n; qclass_q <= qclass_n;
				label_q <= label_n; records_q <= records_n;
				differs_q <= differs_n; end_bad_q <= end_bad_n;
			end
		end
	end

endmodule

// File: sv/lqc_out_reg.sv
// Result register holding one verdict beat until downstream takes it.
module lqc_out_reg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  lqc_pkg::result_t  res_in,
	input  logic              stall,
	output logic              valid,
	output lqc_pkg::result_t  res_out
);

	logic             valid_q;
	lqc_pkg::result_t res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (!stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res_in;
		end
	end

	assign valid   = valid_q;
	assign res_out = res_q;

endmodule

// File: sv/llmnr_query_classifier.sv
// LLMNR query classifier: header, name and question checks on a byte stream.
// Latency: the verdict appears in the cycle after the last byte is accepted.
// Throughput: one byte per cycle, except while a last byte is held by query_stall; set by the single-pass parse logic.
// A last byte waits only while a previous verdict is still held by result_stall.
// Reset clears parse state, the result valid and the host name registers.
module llmnr_query_classifier (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          query_valid,
	output logic                          query_stall,
	input  logic [7:0]                    data_byte,
	input  logic                          last_byte,
	output logic                          result_valid,
	input  logic                          result_stall,
	output logic [2:0]                    verdict,
	output logic [1:0]                    addr_family,
	output logic [15:0]                   transaction_id,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [lqc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [63:0]                   cfg_data
);

	lqc_pkg::host_cfg_t cfg;
	lqc_pkg::result_t   res_next, res_out;
	logic               accept, accept_last;

	assign cfg_ready   = 1'b1;
	// only a last beat needs room in the result register
	assign query_stall = result_valid && result_stall && last_byte;
	assign accept      = query_valid && !query_stall;
	assign accept_last = accept && last_byte;

	lqc_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	lqc_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.data_byte (data_byte),
		.last_byte (last_byte),
		.cfg       (cfg),
		.res       (res_next)
	);

	lqc_out_reg u_out (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (accept_last),
		.res_in  (res_next),
		.stall   (result_stall),
		.valid   (result_valid),
		.res_out (res_out)
	);

	assign verdict        = res_out.verdict;
	assign addr_family    = res_out.family;
	assign transaction_id = res_out.ident;

	a_family_only_on_respond: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && verdict != lqc_pkg::VERDICT_RESPOND |-> addr_family == 2'd0)
		else $error("address family set on a rejected query");

	a_no_result_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		!(accept_last && result_valid && result_stall))
		else $error("verdict accepted while result register is held");

	a_last_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		accept_last |=> result_valid)
		else $error("last byte accepted without a verdict");

	a_family_legal: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> addr_family != 2'd3)
		else $error("illegal address family code");

endmodule
